// ----- rtl/cwfir_pkg.sv -----
// ----------------------------------------------------------------------------
// cwfir_pkg: shared types and constants
// Field widths, codes and the controller/datapath command and status bundles
// of the circular window fir filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cwfir_pkg;

  // field widths
  localparam int IDX_W  = 10;
  localparam int SMP_W  = 32;
  localparam int COEF_W = 18;
  localparam int FW_W   = 7;
  localparam int LEN_W  = 11;
  localparam int CFG_W  = 11;
  localparam int ACC_W  = 64;
  localparam int PROD_W = SMP_W + COEF_W;

  // default sizes of the stores
  localparam int MAX_LEN_DEF  = 1024;
  localparam int MAX_TAPS_DEF = 64;

  // reset values of the configuration registers
  localparam logic [FW_W-1:0]  FILTER_WIDTH_RST  = FW_W'(3);
  localparam logic [LEN_W-1:0] SERIES_LENGTH_RST = LEN_W'(1024);

  // request opcodes
  localparam logic [1:0] OP_LOAD_COEF   = 2'd0;
  localparam logic [1:0] OP_LOAD_SAMPLE = 2'd1;
  localparam logic [1:0] OP_READ_POINT  = 2'd2;

  // configuration register indexes
  localparam logic REG_FILTER_WIDTH  = 1'b0;
  localparam logic REG_SERIES_LENGTH = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic wr_coef;     // store coefficient of the accepted request
    logic wr_sample;   // store sample of the accepted request
    logic start;       // latch read index, prime remainder unit, clear acc
    logic rem_step;    // one bit of both remainders
    logic calc_base;   // first sample position, tap counter to zero
    logic issue;       // read one tap and advance position
    logic load_out;    // round, saturate and load output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rem_last;    // last remainder bit this cycle
    logic taps_zero;   // no taps to apply
    logic last_tap;    // last tap issued this cycle
    logic pipe_busy;   // products still in flight
    logic out_busy;    // output register holds an untaken result
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/cwfir_ctrl.sv -----
// ----------------------------------------------------------------------------
// cwfir_ctrl: request sequencer
// Steps a read request through remainder, base, tap issue, drain and output.
// ----------------------------------------------------------------------------
`default_nettype none

module cwfir_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         opcode,
  input  wire cwfir_pkg::status_t sts,
  output cwfir_pkg::cmd_t         cmd
);
  import cwfir_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_REM   = 6'b000010,
    S_BASE  = 6'b000100,
    S_MAC   = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.wr_coef   = accept && (opcode == OP_LOAD_COEF);
    cmd.wr_sample = accept && (opcode == OP_LOAD_SAMPLE);
    unique case (state)
      S_IDLE: begin
        if (accept && (opcode == OP_READ_POINT)) begin
          cmd.start  = 1'b1;
          state_next = S_REM;
        end
      end
      S_REM: begin
        cmd.rem_step = 1'b1;
        if (sts.rem_last) begin
          state_next = S_BASE;
        end
      end
      S_BASE: begin
        cmd.calc_base = 1'b1;
        state_next    = sts.taps_zero ? S_DRAIN : S_MAC;
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        if (sts.last_tap) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cwfir_dp.sv -----
// ----------------------------------------------------------------------------
// cwfir_dp: filter datapath
// Configuration registers, sample and coefficient stores, bit-serial index
// remainders, circular position counter, multiply-accumulate and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cwfir_dp #(
  parameter int MAX_LEN  = cwfir_pkg::MAX_LEN_DEF,
  parameter int MAX_TAPS = cwfir_pkg::MAX_TAPS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic                                   cfg_index,
  input  wire logic        [cwfir_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic        [cwfir_pkg::IDX_W-1:0]     index,
  input  wire logic signed [cwfir_pkg::SMP_W-1:0]     sample,
  input  wire logic signed [cwfir_pkg::COEF_W-1:0]    coefficient,
  input  wire cwfir_pkg::cmd_t                        cmd,
  output cwfir_pkg::status_t                          sts,
  input  wire logic                                   out_ready,
  output logic                                        out_valid,
  output logic signed      [cwfir_pkg::SMP_W-1:0]     filtered_value,
  output logic             [cwfir_pkg::IDX_W-1:0]     out_index
);
  import cwfir_pkg::*;

  localparam int SA_W    = $clog2(MAX_LEN);
  localparam int KA_W    = $clog2(MAX_TAPS);
  localparam int LEN_CAP = (MAX_LEN > 2047) ? 2047 : MAX_LEN;
  localparam int FW_CAP  = (MAX_TAPS > 127) ? 127 : MAX_TAPS;
  localparam int STEP_W  = $clog2(IDX_W);

  // remainder step: shift in one dividend bit, subtract modulus if it fits
  function automatic logic [LEN_W-1:0] rem_bit(input logic [LEN_W-1:0] r,
                                               input logic b,
                                               input logic [LEN_W-1:0] m);
    logic [LEN_W:0] t;
    begin
      t = {r, b};
      if (t >= {1'b0, m}) begin
        t = t - {1'b0, m};
      end
      return t[LEN_W-1:0];
    end
  endfunction

  // configuration
  logic [FW_W-1:0]  filter_width;
  logic [LEN_W-1:0] series_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_width  <= FILTER_WIDTH_RST;
      series_length <= SERIES_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_WIDTH:  filter_width  <= cfg_data[FW_W-1:0];
        REG_SERIES_LENGTH: series_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective width, taps, half and modulus
  logic [FW_W-1:0]  w_sat;
  logic [FW_W-1:0]  taps;
  logic [IDX_W-1:0] half;
  logic [LEN_W-1:0] len;

  always_comb begin
    w_sat = (32'(filter_width) > FW_CAP) ? FW_W'(FW_CAP) : filter_width;
    taps  = (w_sat != '0) ? w_sat - FW_W'(1) : '0;
    half  = IDX_W'(taps >> 1);
    if (series_length == '0) begin
      len = LEN_W'(1);
    end else if (32'(series_length) > LEN_CAP) begin
      len = LEN_W'(LEN_CAP);
    end else begin
      len = series_length;
    end
  end

  // stores
  logic signed [SMP_W-1:0]  sample_store [MAX_LEN];
  logic signed [COEF_W-1:0] coef_store   [MAX_TAPS];
  logic signed [SMP_W-1:0]  x_rd;
  logic signed [COEF_W-1:0] c_rd;

  logic [LEN_W-1:0] pos;
  logic [FW_W-1:0]  k;

  always_ff @(posedge clk) begin
    if (cmd.wr_sample && (32'(index) < MAX_LEN)) begin
      sample_store[SA_W'(index)] <= sample;
    end
    x_rd <= sample_store[SA_W'(pos)];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_coef && (32'(index) < MAX_TAPS)) begin
      coef_store[KA_W'(index)] <= coefficient;
    end
    c_rd <= coef_store[KA_W'(k)];
  end

  // bit-serial remainders of the read index and of half
  logic [IDX_W-1:0]  idx_req;
  logic [IDX_W-1:0]  idx_sh;
  logic [IDX_W-1:0]  half_sh;
  logic [LEN_W-1:0]  rem_idx;
  logic [LEN_W-1:0]  rem_half;
  logic [STEP_W-1:0] step;
  logic [LEN_W:0]    base;
  logic [LEN_W-1:0]  pos_inc;

  assign base    = {1'b0, rem_idx} + {1'b0, len} - {1'b0, rem_half};
  assign pos_inc = pos + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_req  <= index;
      idx_sh   <= index;
      half_sh  <= half;
      rem_idx  <= '0;
      rem_half <= '0;
      step     <= '0;
    end else if (cmd.rem_step) begin
      rem_idx  <= rem_bit(rem_idx, idx_sh[IDX_W-1], len);
      rem_half <= rem_bit(rem_half, half_sh[IDX_W-1], len);
      idx_sh   <= idx_sh << 1;
      half_sh  <= half_sh << 1;
      step     <= step + STEP_W'(1);
    end
    if (cmd.calc_base) begin
      pos <= (base >= {1'b0, len}) ? LEN_W'(base - {1'b0, len}) : LEN_W'(base);
      k   <= '0;
    end else if (cmd.issue) begin
      pos <= (pos_inc == len) ? '0 : pos_inc;
      k   <= k + FW_W'(1);
    end
  end

  // multiply-accumulate pipeline
  logic                     v1, v2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= x_rd * c_rd;
    if (cmd.start) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round to nearest, ties up, then saturate to q16.16
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-1:0] q;
  logic signed [SMP_W-1:0] q_sat;

  always_comb begin
    acc_rnd = acc + ACC_W'(32768);
    q       = acc_rnd >>> 16;
    if (q > ACC_W'(64'sh7FFF_FFFF)) begin
      q_sat = {1'b0, {(SMP_W-1){1'b1}}};
    end else if (q < -ACC_W'(64'sh8000_0000)) begin
      q_sat = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      q_sat = q[SMP_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      filtered_value <= q_sat;
      out_index      <= idx_req;
    end
  end

  // status
  assign sts.rem_last  = (step == STEP_W'(IDX_W - 1));
  assign sts.taps_zero = (taps == '0);
  assign sts.last_tap  = (k == taps - FW_W'(1));
  assign sts.pipe_busy = v1 || v2;
  assign sts.out_busy  = out_valid && !out_ready;

endmodule

`default_nettype wire

// ----- rtl/circular_window_fir_filter_top.sv -----
// ----------------------------------------------------------------------------
// circular_window_fir_filter_top: circular window fir filter
// Loads window coefficients and a time series by index and returns filtered
// points with circular wrap, q16.16 rounded and saturated.
// ----------------------------------------------------------------------------
// loads: written to their store in the cycle they are accepted
// read: steps through index remainders, base, tap issue (skipped with no
//   taps), mac drain and output load; taps = filter_width - 1, width capped
// throughput: one tap per cycle through a single multiply-accumulate; a read
//   holds the block until its result is in the output register
// reset: synchronous, active high; clears config to width 3, length 1024 and
//   the sequencer; the stores are not cleared and hold garbage until written
`default_nettype none

module circular_window_fir_filter_top #(
  parameter int MAX_LEN  = cwfir_pkg::MAX_LEN_DEF,
  parameter int MAX_TAPS = cwfir_pkg::MAX_TAPS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_index,
  input  wire logic        [cwfir_pkg::CFG_W-1:0]  cfg_data,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic        [1:0]                   opcode,
  input  wire logic        [cwfir_pkg::IDX_W-1:0]  index,
  input  wire logic signed [cwfir_pkg::SMP_W-1:0]  sample,
  input  wire logic signed [cwfir_pkg::COEF_W-1:0] coefficient,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [cwfir_pkg::SMP_W-1:0]  filtered_value,
  output logic             [cwfir_pkg::IDX_W-1:0]  out_index
);
  import cwfir_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t sts;

  // sequencer: one request at a time, opcode decode for the stores
  cwfir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: stores, remainder unit, position walk, mac and output register;
  // the output register lets the next request in while a result waits
  cwfir_dp #(
    .MAX_LEN  (MAX_LEN),
    .MAX_TAPS (MAX_TAPS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .index          (index),
    .sample         (sample),
    .coefficient    (coefficient),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .filtered_value (filtered_value),
    .out_index      (out_index)
  );

endmodule

`default_nettype wire
